@@ src/column_mode_imputation_unit_defines.svh @@
// Assertion helpers shared by the block's RTL files.
// Each macro uses the i_clk clock and the active-low i_rst_n reset of the
// module that uses it.
`ifndef COLUMN_MODE_IMPUTATION_UNIT_DEFINES_SVH
`define COLUMN_MODE_IMPUTATION_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define CMI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define CMI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CMI_ASSERT_IMP(lbl, ante, cons, msg)
`define CMI_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ src/cmi_pkg.sv @@
package cmi_pkg;

    // Default sizes of the block
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int MAX_COLUMNS_DEF = 64;
    localparam int COUNT_BITS_DEF  = 16;

    // Fixed field widths
    localparam int VALUE_W  = 32;
    localparam int COLUMN_W = 6;
    localparam int LABEL_W  = 6;
    localparam int MCOUNT_W = 16;

    // Operation codes
    localparam logic OP_LEARN = 1'b0;
    localparam logic OP_FILL  = 1'b1;

    // Result kinds
    localparam logic KIND_FILL = 1'b0;
    localparam logic KIND_MODE = 1'b1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_RUN,
        S_FILL,
        S_MODE
    } t_cmi_state;

    typedef struct packed {
        logic                        operation;
        logic [COLUMN_W-1:0]         column;
        logic signed [VALUE_W-1:0]   cell_value;
        logic                        cell_missing;
        logic                        last_of_column;
    } t_cmi_in;

    typedef struct packed {
        logic                        result_kind;
        logic signed [VALUE_W-1:0]   out_value;
        logic                        out_missing;
        logic [MCOUNT_W-1:0]         mode_count;
        logic                        table_overflow;
    } t_cmi_out;

    // What one cell hands to the next: a value looking for its entry, and the
    // end-of-column mark with the best value found so far.
    typedef struct packed {
        logic               tok_valid;
        logic [VALUE_W-1:0] tok_value;
        logic               mark;
        logic [VALUE_W-1:0] best_value;
    } t_cmi_link;

endpackage

@@ src/cmi_ram.sv @@
module cmi_ram #(
    parameter int WIDTH = cmi_pkg::VALUE_W,
    parameter int DEPTH = cmi_pkg::MAX_COLUMNS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds its data between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/cmi_cell.sv @@
module cmi_cell #(
    parameter int COUNT_BITS = cmi_pkg::COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  cmi_pkg::t_cmi_link    i_link,
    input  logic [COUNT_BITS-1:0] i_best,
    output cmi_pkg::t_cmi_link    o_link,
    output logic [COUNT_BITS-1:0] o_best
);

    import cmi_pkg::*;

    logic                  r_used, n_used;
    logic [VALUE_W-1:0]    r_value, n_value;
    logic [COUNT_BITS-1:0] r_count, n_count;
    t_cmi_link             r_link, n_link;
    logic [COUNT_BITS-1:0] r_best, n_best;

    logic                  hit;
    logic                  take;
    logic                  used_upd;
    logic [VALUE_W-1:0]    val_upd;
    logic [COUNT_BITS-1:0] cnt_upd;
    logic                  better;

    // Match or claim this entry, then let the mark read and clear it
    always_comb begin
        hit  = i_link.tok_valid && r_used && (r_value == i_link.tok_value);
        take = i_link.tok_valid && !r_used;

        if (hit) begin
            cnt_upd = (r_count == {COUNT_BITS{1'b1}}) ? r_count
                                                      : r_count + COUNT_BITS'(1);
        end else if (take) begin
            cnt_upd = COUNT_BITS'(1);
        end else begin
            cnt_upd = r_count;
        end
        used_upd = r_used || take;
        val_upd  = take ? i_link.tok_value : r_value;

        // strict compare keeps the earliest entry on ties
        better = used_upd && (cnt_upd > i_best);

        n_link           = i_link;
        n_link.tok_valid = i_link.tok_valid && !hit && !take;
        n_best           = i_best;
        n_used           = used_upd;
        n_value          = val_upd;
        n_count          = cnt_upd;

        if (i_link.mark) begin
            if (better) begin
                n_link.best_value = val_upd;
                n_best            = cnt_upd;
            end
            n_used = 1'b0;
        end
    end

    // Control state and the outgoing link
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_link <= '0;
            r_best <= '0;
        end else if (i_adv) begin
            r_used <= n_used;
            r_link <= n_link;
            r_best <= n_best;
        end
    end

    // Entry payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_value <= n_value;
            r_count <= n_count;
        end
    end

    assign o_link = r_link;
    assign o_best = r_best;

endmodule

@@ src/column_mode_imputation_unit.sv @@
// Column mode imputation unit.
// Input channel (i_in_valid / o_in_stall, payload i_in) takes learn and fill
// items; output channel (o_out_valid / i_out_stall, payload o_out) returns
// filled cells and finished column modes. Register label_columns is written
// on the cfg channel (i_cfg_valid / o_cfg_ready, i_cfg_data); the user must
// write it only while idle; the block does not enforce it. Learn cells flow
// down a chain of TABLE_DEPTH cells, one value/count entry per cell; a learn
// item is taken every cycle unless a fill or a frozen chain holds it. The
// cell marked last carries an end mark down the chain that picks the mode
// and clears each entry; its result is registered as the mark leaves. While
// that mark travels, only learn cells that do not end a column are taken. A
// fill item reads the column mode memory; the next item is taken once its
// result is registered. After reset the mode memory is swept to mark every
// column's mode absent; no item is taken during the sweep, config writes
// are. A stalled result stays in the output register; a mark reaching the
// chain end freezes the chain until the register can take its result.
`include "column_mode_imputation_unit_defines.svh"

module column_mode_imputation_unit #(
    parameter int TABLE_DEPTH = cmi_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_COLUMNS = cmi_pkg::MAX_COLUMNS_DEF,
    parameter int COUNT_BITS  = cmi_pkg::COUNT_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [cmi_pkg::LABEL_W-1:0]  i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  cmi_pkg::t_cmi_in             i_in,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output cmi_pkg::t_cmi_out            o_out
);

    import cmi_pkg::*;

    localparam int COL_AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int RAM_W  = VALUE_W + 1;

    t_cmi_state          r_state, n_state;
    logic [LABEL_W-1:0]  r_label;
    logic [COL_AW-1:0]   r_clr, n_clr;
    logic [COL_AW-1:0]   r_mode_col, n_mode_col;
    logic                r_ovf, n_ovf;
    logic                r_out_valid, n_out_valid;
    t_cmi_out            r_out, n_out;
    t_cmi_in             r_fill, n_fill;
    logic                r_fill_attr, n_fill_attr;

    t_cmi_link             link [TABLE_DEPTH+1];
    logic [COUNT_BITS-1:0] best [TABLE_DEPTH+1];
    t_cmi_link             head_link;

    logic [31:0]         col_ext;
    logic                in_attr;
    logic [COL_AW-1:0]   in_addr;
    logic                out_free;
    logic                adv;
    logic                can_take;
    logic                accept;
    logic                mode_found;
    logic [31:0]         best_ext;
    logic [MCOUNT_W-1:0] best_sat;

    logic                ram_we;
    logic [COL_AW-1:0]   ram_waddr;
    logic [RAM_W-1:0]    ram_wdata;
    logic                ram_re;
    logic [RAM_W-1:0]    ram_rdata;

    // Decode the incoming item and the chain handshake
    always_comb begin
        col_ext  = 32'(i_in.column);
        in_attr  = (i_in.column >= r_label) && (col_ext < 32'(MAX_COLUMNS));
        in_addr  = col_ext[COL_AW-1:0];
        out_free = !r_out_valid || !i_out_stall;
        adv      = !link[TABLE_DEPTH].mark || out_free;
        case (r_state)
            S_RUN:   can_take = adv;
            S_MODE:  can_take = adv && (i_in.operation == OP_LEARN)
                                && !(in_attr && i_in.last_of_column);
            default: can_take = 1'b0;
        endcase
        accept = i_in_valid && can_take;
    end

    assign o_in_stall  = !can_take;
    assign o_cfg_ready = 1'b1;

    // Feed the head of the chain
    always_comb begin
        head_link.tok_valid  = accept && (i_in.operation == OP_LEARN) && in_attr
                               && !i_in.cell_missing;
        head_link.tok_value  = $unsigned(i_in.cell_value);
        head_link.mark       = accept && (i_in.operation == OP_LEARN) && in_attr
                               && i_in.last_of_column;
        head_link.best_value = '0;
    end

    assign link[0] = head_link;
    assign best[0] = '0;

    // Table cells
    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        cmi_cell #(
            .COUNT_BITS(COUNT_BITS)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_adv  (adv),
            .i_link (link[k]),
            .i_best (best[k]),
            .o_link (link[k+1]),
            .o_best (best[k+1])
        );
    end

    // Column mode memory: present bit over the mode value
    cmi_ram #(
        .WIDTH(RAM_W),
        .DEPTH(MAX_COLUMNS)
    ) u_mode_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(in_addr),
        .o_rdata(ram_rdata)
    );

    // Saturate the mode count to the result field
    always_comb begin
        best_ext   = 32'(best[TABLE_DEPTH]);
        mode_found = (best[TABLE_DEPTH] != '0);
        best_sat   = (best_ext > 32'(16'hFFFF)) ? 16'hFFFF : best_ext[MCOUNT_W-1:0];
    end

    // Sequencer: sweep, fill reads, mode write-back and output register
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_mode_col  = r_mode_col;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_fill      = r_fill;
        n_fill_attr = r_fill_attr;
        ram_we      = 1'b0;
        ram_waddr   = r_clr;
        ram_wdata   = '0;
        ram_re      = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // a value dropped off the chain end means the table was full
        if (adv && link[TABLE_DEPTH].tok_valid) begin
            n_ovf = 1'b1;
        end

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                if (32'(r_clr) == 32'(MAX_COLUMNS - 1)) begin
                    n_state = S_RUN;
                end else begin
                    n_clr = r_clr + COL_AW'(1);
                end
            end
            S_RUN: begin
                if (accept) begin
                    if (i_in.operation == OP_FILL) begin
                        ram_re      = 1'b1;
                        n_fill      = i_in;
                        n_fill_attr = in_attr;
                        n_state     = S_FILL;
                    end else if (in_attr && i_in.last_of_column) begin
                        n_mode_col = in_addr;
                        n_state    = S_MODE;
                    end
                end
            end
            S_FILL: begin
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out.result_kind    = KIND_FILL;
                    n_out.mode_count     = '0;
                    n_out.table_overflow = 1'b0;
                    if (r_fill_attr && r_fill.cell_missing) begin
                        n_out.out_value   = ram_rdata[VALUE_W] ?
                                            $signed(ram_rdata[VALUE_W-1:0]) : '0;
                        n_out.out_missing = !ram_rdata[VALUE_W];
                    end else begin
                        n_out.out_value   = r_fill.cell_value;
                        n_out.out_missing = r_fill.cell_missing;
                    end
                    n_state = S_RUN;
                end
            end
            S_MODE: begin
                if (link[TABLE_DEPTH].mark && adv) begin
                    n_out_valid          = 1'b1;
                    n_out.result_kind    = KIND_MODE;
                    n_out.out_value      = $signed(link[TABLE_DEPTH].best_value);
                    n_out.out_missing    = !mode_found;
                    n_out.mode_count     = best_sat;
                    n_out.table_overflow = r_ovf || link[TABLE_DEPTH].tok_valid;
                    ram_we               = 1'b1;
                    ram_waddr            = r_mode_col;
                    ram_wdata            = {mode_found, link[TABLE_DEPTH].best_value};
                    n_ovf                = 1'b0;
                    n_state              = S_RUN;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_label     <= '0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_label <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_mode_col  <= n_mode_col;
        r_out       <= n_out;
        r_fill      <= n_fill;
        r_fill_attr <= n_fill_attr;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Nothing enters while the mode memory is being swept
    `CMI_ASSERT_IMP(a_no_take_in_clear, r_state == S_CLEAR, o_in_stall,
        "item taken during the mode memory sweep")
    // An end mark only travels while a mode is being formed
    `CMI_ASSERT_IMP(a_mark_only_in_mode, link[TABLE_DEPTH].mark, r_state == S_MODE,
        "end mark at chain end outside mode state")
    // A mark leaving the chain becomes a registered mode result
    `CMI_ASSERT_NXT(a_mark_gives_result, link[TABLE_DEPTH].mark && adv,
        r_out_valid && (r_out.result_kind == KIND_MODE),
        "end mark left the chain without a mode result")
    // While a mark travels, no fill and no second end of column is taken
    `CMI_ASSERT_IMP(a_mode_takes_learn, accept && (r_state == S_MODE),
        (i_in.operation == OP_LEARN) && !link[0].mark,
        "fill or second end of column taken while a mode is pending")

endmodule

@@ dv/cmi_mode_checker.sv @@
// Watches the config, cell and result channels of the mode imputation unit,
// predicts each result from the accepted cells and compares field by field.
module cmi_mode_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [cmi_pkg::LABEL_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  cmi_pkg::t_cmi_in            i_in,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  cmi_pkg::t_cmi_out           i_out,
    output int                          o_fail_count,
    output int                          o_pending
);
    import cmi_pkg::*;

    localparam int                DEPTH     = TABLE_DEPTH_DEF;
    localparam int                COLUMNS   = MAX_COLUMNS_DEF;
    localparam logic [MCOUNT_W-1:0] COUNT_TOP = {MCOUNT_W{1'b1}};

    // Shared value/count table of the column being learned
    logic [VALUE_W-1:0]  seen_values [DEPTH];
    logic [MCOUNT_W-1:0] seen_counts [DEPTH];
    int                  seen_used;
    logic                table_dropped;

    // Learned modes per column
    logic [VALUE_W-1:0]  col_modes [COLUMNS];
    logic [COLUMNS-1:0]  mode_absent;
    logic [LABEL_W-1:0]  label_cols;

    t_cmi_out            due_results [$];
    int                  fails;

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        fails++;
        $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    // Learn or fill one accepted cell; queue the result it causes, if any
    task automatic learn_or_fill(input t_cmi_in c);
        t_cmi_out r;
        logic     attr;
        logic     found;
        int       best;
        r     = '0;
        attr  = (c.column >= label_cols);
        found = 1'b0;
        if (c.operation == OP_FILL) begin
            r.result_kind = KIND_FILL;
            if (attr && c.cell_missing) begin
                r.out_missing = mode_absent[c.column];
                r.out_value   = mode_absent[c.column] ? '0 : col_modes[c.column];
            end else begin
                r.out_value   = c.cell_value;
                r.out_missing = c.cell_missing;
            end
            due_results.push_back(r);
        end else if (attr) begin
            // count a present value, or open a new entry while room is left
            if (!c.cell_missing) begin
                for (int k = 0; k < seen_used; k++) begin
                    if (!found && seen_values[k] == c.cell_value) begin
                        found = 1'b1;
                        if (seen_counts[k] != COUNT_TOP)
                            seen_counts[k] = seen_counts[k] + MCOUNT_W'(1);
                    end
                end
                if (!found) begin
                    if (seen_used < DEPTH) begin
                        seen_values[seen_used] = c.cell_value;
                        seen_counts[seen_used] = MCOUNT_W'(1);
                        seen_used++;
                    end else begin
                        table_dropped = 1'b1;
                    end
                end
            end
            // on the last cell pick the mode, earliest entry wins ties
            if (c.last_of_column) begin
                r.result_kind    = KIND_MODE;
                r.table_overflow = table_dropped;
                if (seen_used == 0) begin
                    mode_absent[c.column] = 1'b1;
                    r.out_missing         = 1'b1;
                end else begin
                    best = 0;
                    for (int k = 1; k < seen_used; k++)
                        if (seen_counts[k] > seen_counts[best])
                            best = k;
                    col_modes[c.column]   = seen_values[best];
                    mode_absent[c.column] = 1'b0;
                    r.out_value           = seen_values[best];
                    r.mode_count          = seen_counts[best];
                end
                for (int k = 0; k < DEPTH; k++)
                    seen_counts[k] = '0;
                seen_used     = 0;
                table_dropped = 1'b0;
                due_results.push_back(r);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_cmi_out want;
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++)
                seen_counts[k] = '0;
            seen_used     = 0;
            table_dropped = 1'b0;
            mode_absent   = '1;
            label_cols    = '0;
            fails         = 0;
            due_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                label_cols = i_cfg_data;
            // compare each result transfer with the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    report_mismatch("result with none expected", '0, i_out.out_value);
                end else begin
                    want = due_results.pop_front();
                    if (i_out.result_kind !== want.result_kind)
                        report_mismatch("result_kind", 32'(want.result_kind),
                                        32'(i_out.result_kind));
                    if (i_out.out_value !== want.out_value)
                        report_mismatch("out_value", want.out_value, i_out.out_value);
                    if (i_out.out_missing !== want.out_missing)
                        report_mismatch("out_missing", 32'(want.out_missing),
                                        32'(i_out.out_missing));
                    if (i_out.mode_count !== want.mode_count)
                        report_mismatch("mode_count", 32'(want.mode_count),
                                        32'(i_out.mode_count));
                    if (i_out.table_overflow !== want.table_overflow)
                        report_mismatch("table_overflow", 32'(want.table_overflow),
                                        32'(i_out.table_overflow));
                end
            end
            if (i_in_valid && !i_in_stall)
                learn_or_fill(i_in);
        end
        o_pending    <= due_results.size();
        o_fail_count <= fails;
    end

endmodule

@@ dv/tb_column_mode_imputation_unit.sv @@
// Drives learn and fill cells into the mode imputation unit under several
// label settings, with random gaps and result stalls; the checker does the rest.
module tb_column_mode_imputation_unit;
    import cmi_pkg::*;

    localparam int SETTLE_CYCLES = TABLE_DEPTH_DEF + 12;
    localparam int PHASE_CELLS   = 200;
    localparam int TOP_COLUMN    = MAX_COLUMNS_DEF - 1;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [LABEL_W-1:0]  i_cfg_data  = '0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    t_cmi_in             i_in        = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_cmi_out            o_out;

    int                  fail_count;
    int                  pending_count;
    logic                calm      = 1'b0;
    int                  calm_left = 0;
    int                  out_hold  = 0;
    int                  label_now = 0;
    int                  cells_sent = 0;

    always #5 i_clk = ~i_clk;

    column_mode_imputation_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    cmi_mode_checker u_mode_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in         (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out        (o_out),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // Alternate between stretches with random idling and stretches without
    always @(posedge i_clk) begin
        if (calm_left == 0) begin
            calm      <= ($urandom_range(0, 2) == 0);
            calm_left <= $urandom_range(100, 400);
        end else begin
            calm_left <= calm_left - 1;
        end
    end

    // Stall the result side for a fresh random count after each transfer
    always @(posedge i_clk) begin
        int hold;
        hold = out_hold;
        if (!i_rst_n)
            hold = 0;
        else if (o_out_valid && !i_out_stall)
            hold = calm ? 0 : $urandom_range(0, 18);
        if (hold > 0) begin
            i_out_stall <= 1'b1;
            out_hold    <= hold - 1;
        end else begin
            i_out_stall <= 1'b0;
            out_hold    <= 0;
        end
    end

    function automatic t_cmi_in make_cell(input logic op, input int col,
                                          input logic [31:0] val, input logic miss,
                                          input logic last);
        t_cmi_in c;
        c.operation      = op;
        c.column         = col[COLUMN_W-1:0];
        c.cell_value     = val;
        c.cell_missing   = miss;
        c.last_of_column = last;
        return c;
    endfunction

    // Favor the extremes of the value range
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Offer one cell after an optional gap and hold it until the transfer
    task automatic send_cell(input t_cmi_in c, input bit no_gap);
        int gap;
        gap = (no_gap || calm) ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= c;
        do @(posedge i_clk); while (o_in_stall);
        if (!(c.operation == OP_LEARN && c.column < label_now))
            cells_sent++;
    endtask

    // Drop valid, wait for every expected result, then let the chain drain
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_label(input int v);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v[LABEL_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        label_now = v;
    endtask

    // Mostly whole columns with repeated values, plus fills, noise and
    // columns left open
    task automatic run_phase(input int budget);
        int           target;
        int           pick;
        int           col;
        int           len;
        int           pool_n;
        bit           wide;
        logic         miss;
        logic [31:0]  val;
        logic [31:0]  pool [4];
        target = cells_sent + budget;
        while (cells_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                col  = $urandom_range(label_now, TOP_COLUMN);
                wide = ($urandom_range(0, 29) == 0);
                if (wide)
                    len = $urandom_range(TABLE_DEPTH_DEF + 2, TABLE_DEPTH_DEF + 16);
                else if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(9, 40);
                else
                    len = $urandom_range(1, 8);
                pool_n = $urandom_range(1, 4);
                for (int k = 0; k < 4; k++)
                    pool[k] = pick_value();
                for (int k = 0; k < len; k++) begin
                    miss = !wide && ($urandom_range(0, 4) == 0);
                    val  = wide ? pool[0] + k : pool[$urandom_range(0, pool_n - 1)];
                    if (miss)
                        val = $urandom;
                    send_cell(make_cell(OP_LEARN, col, val, miss, k == len - 1), 1'b0);
                end
            end else if (pick < 85) begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                    send_cell(make_cell(OP_FILL, $urandom_range(0, TOP_COLUMN), $urandom,
                                        $urandom_range(0, 3) != 0,
                                        1'($urandom_range(0, 1))),
                              1'b0);
            end else if (pick < 95) begin
                send_cell(make_cell(OP_LEARN, $urandom_range(0, TOP_COLUMN), $urandom,
                                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))),
                          1'b0);
            end else begin
                col = $urandom_range(label_now, TOP_COLUMN);
                len = $urandom_range(1, 5);
                for (int k = 0; k < len; k++)
                    send_cell(make_cell(OP_LEARN, col, pick_value(),
                                        $urandom_range(0, 4) == 0, 1'b0), 1'b0);
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_label(0);

        // fill before any learning, and a pass-through of a present cell
        send_cell(make_cell(OP_FILL, 0, 32'h1234_5678, 1'b1, 1'b1), 1'b0);
        send_cell(make_cell(OP_FILL, 5, 32'h8000_0000, 1'b0, 1'b0), 1'b0);
        // tie between two values, earliest wins; last cell missing
        send_cell(make_cell(OP_LEARN, 0, 32'h7FFF_FFFF, 1'b0, 1'b0), 1'b0);
        send_cell(make_cell(OP_LEARN, 0, 32'h8000_0000, 1'b0, 1'b0), 1'b0);
        send_cell(make_cell(OP_LEARN, 0, 32'hDEAD_BEEF, 1'b1, 1'b0), 1'b0);
        send_cell(make_cell(OP_LEARN, 0, 32'h7FFF_FFFF, 1'b0, 1'b0), 1'b0);
        send_cell(make_cell(OP_LEARN, 0, 32'h8000_0000, 1'b0, 1'b0), 1'b0);
        send_cell(make_cell(OP_LEARN, 0, 32'h0000_0000, 1'b1, 1'b1), 1'b0);
        // column with no present cell keeps its mode absent
        send_cell(make_cell(OP_LEARN, TOP_COLUMN, 32'hFFFF_FFFF, 1'b1, 1'b1), 1'b0);
        send_cell(make_cell(OP_FILL, 0, 32'h0000_0000, 1'b1, 1'b0), 1'b0);
        send_cell(make_cell(OP_FILL, TOP_COLUMN, 32'h5555_AAAA, 1'b1, 1'b1), 1'b0);
        send_cell(make_cell(OP_LEARN, 1, 32'h0000_0000, 1'b0, 1'b1), 1'b0);
        send_cell(make_cell(OP_FILL, 1, 32'hFFFF_FFFF, 1'b0, 1'b1), 1'b0);
        // interleaved columns share one table
        send_cell(make_cell(OP_LEARN, 2, 32'h0003_0000, 1'b0, 1'b0), 1'b0);
        send_cell(make_cell(OP_LEARN, 3, 32'h0003_0000, 1'b0, 1'b0), 1'b0);
        send_cell(make_cell(OP_LEARN, 2, 32'h0004_0000, 1'b0, 1'b1), 1'b0);
        send_cell(make_cell(OP_FILL, 2, 32'h0000_0001, 1'b1, 1'b0), 1'b0);

        // all but the top column are labels
        write_label(TOP_COLUMN);
        send_cell(make_cell(OP_LEARN, 10, 32'h0001_0000, 1'b0, 1'b1), 1'b0);
        send_cell(make_cell(OP_FILL, 10, 32'h0002_0000, 1'b1, 1'b0), 1'b0);
        send_cell(make_cell(OP_FILL, TOP_COLUMN, 32'h0002_0000, 1'b1, 1'b0), 1'b0);
        send_cell(make_cell(OP_LEARN, TOP_COLUMN, 32'hFFFF_8000, 1'b0, 1'b1), 1'b0);
        send_cell(make_cell(OP_FILL, TOP_COLUMN, 32'h0000_0000, 1'b1, 1'b0), 1'b0);
        send_cell(make_cell(OP_FILL, 0, 32'h0000_0000, 1'b1, 1'b0), 1'b0);

        // random phases over several label settings
        write_label(0);
        run_phase(PHASE_CELLS);
        write_label(TOP_COLUMN);
        run_phase(PHASE_CELLS);
        write_label(1);
        run_phase(PHASE_CELLS);
        write_label($urandom_range(2, TOP_COLUMN - 1));
        run_phase(PHASE_CELLS);
        write_label(32);
        run_phase(PHASE_CELLS);
        write_label($urandom_range(2, TOP_COLUMN - 1));
        run_phase(PHASE_CELLS);
        write_label(0);
        run_phase(PHASE_CELLS);

        settle();
        if (fail_count == 0 && pending_count == 0)
            $display("** column_mode_imputation_unit: PASSED **");
        else
            $display("** column_mode_imputation_unit: FAILED **");
        $finish;
    end

    // Run limit
    initial begin
        #20_000_000;
        $display("** column_mode_imputation_unit: FAILED **");
        $finish;
    end

endmodule
